// File: hw/rtl/swls_pkg.sv
// shared types, constants and register codes for the lane search block
package swls_pkg;

  // default geometry limits
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_HEIGHT_DEF  = 512;
  localparam int MAX_WINDOWS_DEF = 64;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 19;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD    = 3'd0,
    REG_MARGIN       = 3'd1,
    REG_MIN_PIXELS   = 3'd2,
    REG_WINDOW_COUNT = 3'd3,
    REG_IMAGE_WIDTH  = 3'd4,
    REG_IMAGE_HEIGHT = 3'd5
  } cfg_reg_t;

  // register reset values
  localparam logic [7:0]  THRESHOLD_RST    = 8'd128;
  localparam logic [7:0]  MARGIN_RST       = 8'd20;
  localparam logic [18:0] MIN_PIXELS_RST   = 19'd300;
  localparam logic [6:0]  WINDOW_COUNT_RST = 7'd8;
  localparam logic [10:0] IMAGE_WIDTH_RST  = 11'd640;
  localparam logic [9:0]  IMAGE_HEIGHT_RST = 10'd480;

  // count width and saturation limit of the running totals
  localparam int          CNT_W   = 19;
  localparam logic [18:0] CNT_MAX = 19'h7FFFF;

  typedef struct packed {
    logic [7:0] pixel;
    logic       end_of_frame;
  } swls_in_t;

  typedef struct packed {
    logic [5:0]       window_index;
    logic [9:0]       left_center;
    logic [9:0]       right_center;
    logic [CNT_W-1:0] left_count;
    logic [CNT_W-1:0] right_count;
    logic             left_found;
    logic             right_found;
    logic             last_window;
  } swls_out_t;

endpackage

// File: hw/rtl/swls_div.sv
// restoring divider, one quotient bit per cycle
module swls_div #(
  parameter int DW = 32,
  parameter int VW = 19
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] rem_nxt;
  logic [DW-1:0] quo_r;
  logic [VW-1:0] dvs_r;
  logic [VW:0]   rem_sh;
  logic          ge;

  assign rem_sh  = {rem_r, quo_r[DW-1]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_nxt = ge ? VW'(rem_sh - {1'b0, dvs_r}) : VW'(rem_sh);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DW-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: hw/rtl/sliding_window_lane_search.sv
// top level of the sliding window lane search block
//
// Takes one grey frame in raster order; each pixel beat is followed by a
// histogram write-back step before the next is taken (the column histogram
// is a read-modify-write memory). The pixel marked end of frame starts the
// search, during which the block takes no pixels: a sweep over all columns
// finds the base columns and clears the histogram, then a bit-serial
// divider works out the band height. Each band then scans its left and
// right windows one stored pixel a cycle, emits one result beat, and runs
// the same divider once per recentred side. After reset the histogram is
// cleared by a pass over all columns before the first pixel is taken;
// configuration writes are taken at any time.
module sliding_window_lane_search #(
  parameter int MAX_WIDTH   = swls_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = swls_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_WINDOWS = swls_pkg::MAX_WINDOWS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  swls_pkg::swls_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output swls_pkg::swls_out_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [swls_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swls_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // widths derived from the geometry limits
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int XW1   = $clog2(MAX_WIDTH + 1);
  localparam int YW1   = $clog2(MAX_HEIGHT + 1);
  localparam int KW    = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int KW1   = $clog2(MAX_WINDOWS + 1);
  localparam int PIX_N = MAX_WIDTH * MAX_HEIGHT;
  localparam int N_W   = $clog2(PIX_N + 1);
  localparam int SUM_W = N_W + XW;
  localparam int LB_W  = $clog2((MAX_HEIGHT + 1) * MAX_WIDTH + 1);
  localparam int LW    = (LB_W > 7) ? LB_W : 7;
  localparam int WORDS = (PIX_N + 63) / 64;
  localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int DV_W  = (N_W > 7) ? N_W : 7;
  localparam int EW    = ((XW1 > 8) ? XW1 : 8) + 1;
  localparam int TW    = ((N_W > swls_pkg::CNT_W) ? N_W : swls_pkg::CNT_W) + 1;
  localparam int CC_W_L = YW1;

  // one-hot sequencer
  typedef enum logic [13:0] {
    S_CLR   = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_PWB   = 14'b00000000000100,
    S_HIST  = 14'b00000000001000,
    S_HDIV  = 14'b00000000010000,
    S_SETUP = 14'b00000000100000,
    S_SCAN  = 14'b00000001000000,
    S_SDONE = 14'b00000010000000,
    S_EMIT  = 14'b00000100000000,
    S_UPDL  = 14'b00001000000000,
    S_LDIV  = 14'b00010000000000,
    S_UPDR  = 14'b00100000000000,
    S_RDIV  = 14'b01000000000000,
    S_NEXT  = 14'b10000000000000
  } state_t;

  state_t state_r;

  // configuration registers
  logic [7:0]  thr_r;
  logic [7:0]  mrg_r;
  logic [18:0] minp_r;
  logic [6:0]  nwin_r;
  logic [10:0] wid_r;
  logic [9:0]  hgt_r;

  // clamped geometry
  logic [XW1-1:0] w_c;
  logic [XW1-1:0] mid_c;
  logic [YW1-1:0] hgt_c;
  logic [KW1-1:0] nw_c;

  // pixel intake
  logic [XW-1:0]  pcol_r;
  logic [YW1-1:0] prow_r;
  logic [LW-1:0]  pbase_r;
  logic [XW-1:0]  pcold_r;
  logic           pinc_r;
  logic           peof_r;
  logic           pix_bit;
  logic           pix_store;
  logic [LW-1:0]  pix_lin;
  logic           in_acc;

  // memories
  logic [63:0]       bm_mem [WORDS];
  logic [63:0]       bm_rd_r;
  logic [WA_W-1:0]   bm_raddr;
  logic [CC_W_L-1:0] cc_mem [MAX_WIDTH];
  logic [CC_W_L-1:0] cc_rd_r;
  logic [XW-1:0]     cc_raddr;
  logic [XW-1:0]     cc_waddr;
  logic [CC_W_L-1:0] cc_wdata;
  logic              cc_we;

  // histogram sweep
  logic [XW1-1:0]    hx_r;
  logic              hv_r;
  logic [XW-1:0]     hxd_r;
  logic [CC_W_L-1:0] lmax_r;
  logic [CC_W_L-1:0] rmax_r;
  logic              hist_end;

  // band geometry and centres
  logic [YW1-1:0] h_r;
  logic [KW-1:0]  k_r;
  logic [YW1-1:0] ylo_r;
  logic [LW-1:0]  wbase_r;
  logic [XW-1:0]  lc_r;
  logic [XW-1:0]  rc_r;
  logic           last_c;

  // window scan
  logic           sd_r;
  logic           sis_r;
  logic           sv_r;
  logic [XW1-1:0] sx_r;
  logic [XW1-1:0] x0_r;
  logic [XW1-1:0] x1_r;
  logic [YW1-1:0] sy_r;
  logic [YW1-1:0] ylast_r;
  logic [LW-1:0]  srow_r;
  logic [XW-1:0]  sxd_r;
  logic [5:0]     sbd_r;
  logic [LW-1:0]  s_lin;
  logic [N_W-1:0]   acc_n_r;
  logic [SUM_W-1:0] acc_s_r;

  // window setup arithmetic
  logic [XW-1:0] su_c;
  logic [EW-1:0] su_x0;
  logic [EW-1:0] su_x1;
  logic [YW1:0]  su_yhi;
  logic [YW1:0]  su_ylast;
  logic [YW1:0]  su_ylo1;
  logic          su_empty;

  // per band results
  logic [N_W-1:0]   ln_r;
  logic [N_W-1:0]   rn_r;
  logic [SUM_W-1:0] ls_r;
  logic [SUM_W-1:0] rs_r;
  logic [18:0]      lt_r;
  logic [18:0]      rt_r;
  logic [TW-1:0]    lt_sum;
  logic [TW-1:0]    rt_sum;
  logic [18:0]      lt_nxt;
  logic [18:0]      rt_nxt;
  logic             cond_l;
  logic             cond_r;

  // output register
  logic                out_valid_r;
  logic                emit_go;
  swls_pkg::swls_out_t out_r;

  // shared divider
  logic             div_start;
  logic [SUM_W-1:0] div_a;
  logic [DV_W-1:0]  div_b;
  logic             div_done;
  logic [SUM_W-1:0] div_q;

  // ---------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= swls_pkg::THRESHOLD_RST;
      mrg_r  <= swls_pkg::MARGIN_RST;
      minp_r <= swls_pkg::MIN_PIXELS_RST;
      nwin_r <= swls_pkg::WINDOW_COUNT_RST;
      wid_r  <= swls_pkg::IMAGE_WIDTH_RST;
      hgt_r  <= swls_pkg::IMAGE_HEIGHT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        swls_pkg::REG_THRESHOLD:    thr_r  <= cfg_data[7:0];
        swls_pkg::REG_MARGIN:       mrg_r  <= cfg_data[7:0];
        swls_pkg::REG_MIN_PIXELS:   minp_r <= cfg_data[18:0];
        swls_pkg::REG_WINDOW_COUNT: nwin_r <= cfg_data[6:0];
        swls_pkg::REG_IMAGE_WIDTH:  wid_r  <= cfg_data[10:0];
        swls_pkg::REG_IMAGE_HEIGHT: hgt_r  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // zero counts as one, values above the limit saturate
  always_comb begin
    if (wid_r == '0) w_c = XW1'(1);
    else if (32'(wid_r) > MAX_WIDTH) w_c = XW1'(MAX_WIDTH);
    else w_c = XW1'(wid_r);
    if (hgt_r == '0) hgt_c = YW1'(1);
    else if (32'(hgt_r) > MAX_HEIGHT) hgt_c = YW1'(MAX_HEIGHT);
    else hgt_c = YW1'(hgt_r);
    if (nwin_r == '0) nw_c = KW1'(1);
    else if (32'(nwin_r) > MAX_WINDOWS) nw_c = KW1'(MAX_WINDOWS);
    else nw_c = KW1'(nwin_r);
  end

  assign mid_c = w_c >> 1;

  // ---------------------------------------------------------------------
  // pixel intake
  // ---------------------------------------------------------------------
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign pix_bit   = in_data.pixel > thr_r;
  assign pix_store = (prow_r < hgt_c) && (XW1'(pcol_r) < w_c);
  assign pix_lin   = pbase_r + LW'(pcol_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcol_r  <= '0;
      prow_r  <= '0;
      pbase_r <= '0;
    end else if (in_acc) begin
      if (in_data.end_of_frame) begin
        // frame closes: raster position restarts
        pcol_r  <= '0;
        prow_r  <= '0;
        pbase_r <= '0;
      end else if (prow_r < hgt_c) begin
        if (XW1'(pcol_r) + XW1'(1) >= w_c) begin
          pcol_r  <= '0;
          prow_r  <= prow_r + 1'b1;
          pbase_r <= pbase_r + LW'(MAX_WIDTH);
        end else begin
          pcol_r <= pcol_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pcold_r <= pcol_r;
      pinc_r  <= pix_store && pix_bit;
      peof_r  <= in_data.end_of_frame;
    end
  end

  // ---------------------------------------------------------------------
  // bit image: single bit writes, one word read a cycle
  // ---------------------------------------------------------------------
  assign s_lin    = srow_r + LW'(sx_r);
  assign bm_raddr = s_lin[6 +: WA_W];

  always_ff @(posedge clk) begin
    if (in_acc && pix_store) begin
      bm_mem[pix_lin[6 +: WA_W]][pix_lin[5:0]] <= pix_bit;
    end
    bm_rd_r <= bm_mem[bm_raddr];
  end

  // ---------------------------------------------------------------------
  // column histogram
  // ---------------------------------------------------------------------
  always_comb begin
    cc_raddr = (state_r == S_IDLE) ? pcol_r : hx_r[XW-1:0];
    cc_waddr = hx_r[XW-1:0];
    cc_wdata = '0;
    cc_we    = 1'b0;
    case (state_r)
      S_PWB: begin
        cc_waddr = pcold_r;
        cc_wdata = cc_rd_r + 1'b1;
        cc_we    = pinc_r;
      end
      S_CLR, S_HIST: begin
        cc_we = hx_r < XW1'(MAX_WIDTH);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cc_we) begin
      cc_mem[cc_waddr] <= cc_wdata;
    end
    cc_rd_r <= cc_mem[cc_raddr];
  end

  // sweep ends once every column is issued and the last read is judged
  assign hist_end = (hx_r == XW1'(MAX_WIDTH)) && !hv_r;

  // ---------------------------------------------------------------------
  // band arithmetic
  // ---------------------------------------------------------------------
  assign last_c = (KW1'(k_r) + KW1'(1)) == nw_c;

  always_comb begin
    su_c  = sd_r ? rc_r : lc_r;
    su_x0 = (EW'(su_c) > EW'(mrg_r)) ? EW'(su_c) - EW'(mrg_r) : '0;
    su_x1 = EW'(su_c) + EW'(mrg_r);
    if (su_x1 > EW'(w_c)) su_x1 = EW'(w_c);
    su_yhi   = (YW1 + 1)'(ylo_r) + (YW1 + 1)'(h_r);
    su_ylast = (YW1 + 1)'(hgt_c) - 1'b1;
    if (su_yhi < su_ylast) su_ylast = su_yhi;
    su_ylo1  = (YW1 + 1)'(ylo_r) + 1'b1;
    su_empty = (su_x0 >= su_x1) || (su_ylo1 > su_ylast);
  end

  // saturating running totals
  assign lt_sum = TW'(lt_r) + TW'(ln_r);
  assign rt_sum = TW'(rt_r) + TW'(rn_r);
  assign lt_nxt = (lt_sum > TW'(swls_pkg::CNT_MAX)) ? swls_pkg::CNT_MAX : 19'(lt_sum);
  assign rt_nxt = (rt_sum > TW'(swls_pkg::CNT_MAX)) ? swls_pkg::CNT_MAX : 19'(rt_sum);

  // recentre only on a strong band, and only on the own side of the midline
  assign cond_l = (ln_r > N_W'(minp_r)) && (XW1'(lc_r) < mid_c);
  assign cond_r = (rn_r > N_W'(minp_r)) && (XW1'(rc_r) > mid_c);

  // ---------------------------------------------------------------------
  // shared divider: band height, then the mean column of each side
  // ---------------------------------------------------------------------
  always_comb begin
    div_start = 1'b0;
    div_a     = rs_r;
    div_b     = DV_W'(rn_r);
    case (state_r)
      S_HIST: begin
        div_start = hist_end;
        div_a     = SUM_W'(hgt_c);
        div_b     = DV_W'(nw_c);
      end
      S_UPDL: begin
        div_start = cond_l;
        div_a     = ls_r;
        div_b     = DV_W'(ln_r);
      end
      S_UPDR: begin
        div_start = cond_r;
      end
      default: ;
    endcase
  end

  swls_div #(
    .DW(SUM_W),
    .VW(DV_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  // ---------------------------------------------------------------------
  // result beat: loaded from the emit step, held until taken
  // ---------------------------------------------------------------------
  assign emit_go = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      hx_r    <= '0;
      hv_r    <= 1'b0;
      sis_r   <= 1'b0;
      sv_r    <= 1'b0;
      sd_r    <= 1'b0;
    end else begin
      case (state_r)
        S_CLR: begin
          if (hx_r == XW1'(MAX_WIDTH)) state_r <= S_IDLE;
          else hx_r <= hx_r + 1'b1;
        end
        S_IDLE: begin
          if (in_acc) state_r <= S_PWB;
        end
        S_PWB: begin
          if (peof_r) begin
            state_r <= S_HIST;
            hx_r    <= '0;
            hv_r    <= 1'b0;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_HIST: begin
          hv_r <= hx_r < XW1'(MAX_WIDTH);
          if (hx_r < XW1'(MAX_WIDTH)) hx_r <= hx_r + 1'b1;
          if (hist_end) state_r <= S_HDIV;
        end
        S_HDIV: begin
          if (div_done) begin
            state_r <= S_SETUP;
            sd_r    <= 1'b0;
          end
        end
        S_SETUP: begin
          if (su_empty) begin
            state_r <= S_SDONE;
          end else begin
            state_r <= S_SCAN;
            sis_r   <= 1'b1;
          end
        end
        S_SCAN: begin
          sv_r <= sis_r;
          if (sis_r && (sx_r + 1'b1 >= x1_r) && (sy_r == ylast_r)) sis_r <= 1'b0;
          if (!sis_r && !sv_r) state_r <= S_SDONE;
        end
        S_SDONE: begin
          if (!sd_r) begin
            sd_r    <= 1'b1;
            state_r <= S_SETUP;
          end else begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_go) state_r <= S_UPDL;
        end
        S_UPDL: begin
          state_r <= cond_l ? S_LDIV : S_UPDR;
        end
        S_LDIV: begin
          if (div_done) state_r <= S_UPDR;
        end
        S_UPDR: begin
          state_r <= cond_r ? S_RDIV : S_NEXT;
        end
        S_RDIV: begin
          if (div_done) state_r <= S_NEXT;
        end
        S_NEXT: begin
          sd_r    <= 1'b0;
          state_r <= last_c ? S_IDLE : S_SETUP;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // datapath registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    hxd_r <= hx_r[XW-1:0];
    case (state_r)
      S_PWB: begin
        lc_r <= '0;
        lt_r <= '0;
        rt_r <= '0;
      end
      S_HIST: begin
        // first maximum of each half wins
        if (hv_r && (XW1'(hxd_r) < w_c)) begin
          if (XW1'(hxd_r) < mid_c) begin
            if (hxd_r == '0 || cc_rd_r > lmax_r) begin
              lmax_r <= cc_rd_r;
              lc_r   <= hxd_r;
            end
          end else if (XW1'(hxd_r) == mid_c || cc_rd_r > rmax_r) begin
            rmax_r <= cc_rd_r;
            rc_r   <= hxd_r;
          end
        end
      end
      S_HDIV: begin
        h_r     <= YW1'(div_q);
        k_r     <= '0;
        ylo_r   <= '0;
        wbase_r <= LW'(MAX_WIDTH);
      end
      S_SETUP: begin
        acc_n_r <= '0;
        acc_s_r <= '0;
        x0_r    <= XW1'(su_x0);
        x1_r    <= XW1'(su_x1);
        sx_r    <= XW1'(su_x0);
        sy_r    <= YW1'(su_ylo1);
        ylast_r <= YW1'(su_ylast);
        srow_r  <= wbase_r;
      end
      S_SCAN: begin
        if (sis_r) begin
          sxd_r <= XW'(sx_r);
          sbd_r <= s_lin[5:0];
          if (sx_r + 1'b1 >= x1_r) begin
            sx_r <= x0_r;
            if (sy_r != ylast_r) begin
              sy_r   <= sy_r + 1'b1;
              srow_r <= srow_r + LW'(MAX_WIDTH);
            end
          end else begin
            sx_r <= sx_r + 1'b1;
          end
        end
        if (sv_r && bm_rd_r[sbd_r]) begin
          acc_n_r <= acc_n_r + 1'b1;
          acc_s_r <= acc_s_r + SUM_W'(sxd_r);
        end
      end
      S_SDONE: begin
        if (!sd_r) begin
          ln_r <= acc_n_r;
          ls_r <= acc_s_r;
        end else begin
          rn_r <= acc_n_r;
          rs_r <= acc_s_r;
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          lt_r <= lt_nxt;
          rt_r <= rt_nxt;
          out_r.window_index <= 6'(k_r);
          out_r.left_center  <= 10'(lc_r);
          out_r.right_center <= 10'(rc_r);
          out_r.left_count   <= swls_pkg::CNT_W'(ln_r);
          out_r.right_count  <= swls_pkg::CNT_W'(rn_r);
          out_r.left_found   <= last_c && (lt_nxt > minp_r);
          out_r.right_found  <= last_c && (rt_nxt > minp_r);
          out_r.last_window  <= last_c;
        end
      end
      S_LDIV: begin
        if (div_done) lc_r <= XW'(div_q);
      end
      S_RDIV: begin
        if (div_done) rc_r <= XW'(div_q);
      end
      S_NEXT: begin
        k_r     <= k_r + 1'b1;
        ylo_r   <= ylo_r + h_r;
        wbase_r <= wbase_r + LW'(h_r * MAX_WIDTH);
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // a pixel beat always gets its histogram write-back cycle
  a_pix_wb: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_PWB)
    else $error("pixel beat not followed by write-back");

  // the divider only finishes while the sequencer waits for it
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_HDIV || state_r == S_LDIV || state_r == S_RDIV))
    else $error("divider result with nobody waiting");

  // a result beat only appears from the emit step
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_EMIT))
    else $error("result beat raised outside emit");

  // no pixel is taken while a window scan is still issuing reads
  a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
    sis_r |-> !in_ready)
    else $error("pixel intake open during scan");
`endif

endmodule

// File: bench/lane_search_checker.sv
// checker for the lane search block: predicts band results and compares them
`timescale 1ns / 1ps

module lane_search_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  swls_pkg::swls_in_t            in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  swls_pkg::swls_out_t           out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [swls_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swls_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                            errors,
  output int                            pending
);

  localparam int MW = swls_pkg::MAX_WIDTH_DEF;
  localparam int MH = swls_pkg::MAX_HEIGHT_DEF;
  localparam int MWIN = swls_pkg::MAX_WINDOWS_DEF;

  logic [7:0]  thr;
  logic [7:0]  mg;
  logic [18:0] min_px;
  logic [6:0]  nwin_reg;
  logic [10:0] width_reg;
  logic [9:0]  height_reg;

  bit          lane_bits [0:MH-1][0:MW-1];
  int unsigned col_hits [0:MW-1];
  int unsigned col_pos, row_pos, left_sum, right_sum;
  swls_pkg::swls_out_t band_q [$];

  function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // set pixels and their column sum in rows (ylo, yhi] and columns [c-m, c+m)
  function automatic int unsigned window_hits(int ylo, int yhi, int c, int w, int hgt,
                                               output longint unsigned xsum);
    int x0, x1;
    int unsigned n;
    x0 = c - int'(mg);
    x1 = c + int'(mg);
    n = 0;
    xsum = 0;
    if (x0 < 0) x0 = 0;
    if (x1 > w) x1 = w;
    if (yhi > hgt - 1) yhi = hgt - 1;
    for (int y = ylo + 1; y <= yhi; y++)
      for (int x = x0; x < x1; x++)
        if (lane_bits[y][x]) begin
          n++;
          xsum += x;
        end
    return n;
  endfunction

  function automatic int unsigned add_sat(int unsigned a, int unsigned b);
    return (a + b > swls_pkg::CNT_MAX) ? swls_pkg::CNT_MAX : a + b;
  endfunction

  // base columns, then one result per band with recentring
  task automatic search_bands();
    int unsigned w, hgt, nw, mid, bh, lc, rc, ln, rn;
    longint unsigned ls, rs;
    swls_pkg::swls_out_t r;
    w   = clip(width_reg, 1, MW);
    hgt = clip(height_reg, 1, MH);
    nw  = clip(nwin_reg, 1, MWIN);
    mid = w / 2;
    bh  = hgt / nw;
    lc  = 0;
    rc  = mid;
    for (int unsigned x = 1; x < mid; x++)
      if (col_hits[x] > col_hits[lc]) lc = x;
    for (int unsigned x = mid + 1; x < w; x++)
      if (col_hits[x] > col_hits[rc]) rc = x;
    for (int unsigned k = 0; k < nw; k++) begin
      ln = window_hits(k * bh, (k + 1) * bh, lc, w, hgt, ls);
      rn = window_hits(k * bh, (k + 1) * bh, rc, w, hgt, rs);
      left_sum  = add_sat(left_sum, ln);
      right_sum = add_sat(right_sum, rn);
      r.window_index = k[5:0];
      r.left_center  = lc[9:0];
      r.right_center = rc[9:0];
      r.left_count   = ln[18:0];
      r.right_count  = rn[18:0];
      r.last_window  = (k + 1 == nw);
      r.left_found   = r.last_window && left_sum > min_px;
      r.right_found  = r.last_window && right_sum > min_px;
      band_q = {band_q, r};
      if (ln > min_px && lc < mid) lc = ls / ln;
      if (rn > min_px && rc > mid) rc = rs / rn;
    end
  endtask

  task automatic take_pixel(swls_pkg::swls_in_t p);
    int unsigned w, hgt;
    bit on;
    w   = clip(width_reg, 1, MW);
    hgt = clip(height_reg, 1, MH);
    on  = p.pixel > thr;
    if (row_pos < hgt && col_pos < w) begin
      lane_bits[row_pos][col_pos] = on;
      if (on) col_hits[col_pos]++;
    end
    if (row_pos < hgt) begin
      if (col_pos + 1 >= w) begin
        col_pos = 0;
        row_pos++;
      end else begin
        col_pos++;
      end
    end
    if (p.end_of_frame) begin
      search_bands();
      for (int i = 0; i < MW; i++) col_hits[i] = 0;
      col_pos = 0;
      row_pos = 0;
      left_sum = 0;
      right_sum = 0;
    end
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    swls_pkg::swls_out_t e;
    if (!rst_n) begin
      thr = swls_pkg::THRESHOLD_RST;
      mg = swls_pkg::MARGIN_RST;
      min_px = swls_pkg::MIN_PIXELS_RST;
      nwin_reg = swls_pkg::WINDOW_COUNT_RST;
      width_reg = swls_pkg::IMAGE_WIDTH_RST;
      height_reg = swls_pkg::IMAGE_HEIGHT_RST;
      for (int i = 0; i < MW; i++) col_hits[i] = 0;
      col_pos = 0;
      row_pos = 0;
      left_sum = 0;
      right_sum = 0;
      band_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (swls_pkg::cfg_reg_t'(cfg_index))
          swls_pkg::REG_THRESHOLD:    thr = cfg_data[7:0];
          swls_pkg::REG_MARGIN:       mg = cfg_data[7:0];
          swls_pkg::REG_MIN_PIXELS:   min_px = cfg_data[18:0];
          swls_pkg::REG_WINDOW_COUNT: nwin_reg = cfg_data[6:0];
          swls_pkg::REG_IMAGE_WIDTH:  width_reg = cfg_data[10:0];
          swls_pkg::REG_IMAGE_HEIGHT: height_reg = cfg_data[9:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) take_pixel(in_data);
      if (out_valid && out_ready) begin
        if (band_q.size() == 0) begin
          $error("result beat with no band expected");
          errors++;
        end else begin
          e = band_q.pop_front();
          check_field("window_index", e.window_index, out_data.window_index);
          check_field("left_center", e.left_center, out_data.left_center);
          check_field("right_center", e.right_center, out_data.right_center);
          check_field("left_count", e.left_count, out_data.left_count);
          check_field("right_count", e.right_count, out_data.right_count);
          check_field("left_found", e.left_found, out_data.left_found);
          check_field("right_found", e.right_found, out_data.right_found);
          check_field("last_window", e.last_window, out_data.last_window);
        end
      end
    end
    pending <= band_q.size();
  end

endmodule

// File: bench/testbench.sv
// top of the lane search bench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  swls_pkg::swls_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  swls_pkg::swls_out_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [swls_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [swls_pkg::CFG_DATA_W-1:0] cfg_data;
  int        errors;
  int        pending;

  // pixel beats left in the current sender burst
  int        burst_left;
  // cycle count and mode of the receiver stall pattern
  int        stall_cyc;
  int        stall_mode;

  sliding_window_lane_search dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  lane_search_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // hard stop, far beyond the slowest correct run
  initial begin
    #10ms;
    $display("FAILURE");
    $finish;
  end

  // receiver: the mode is redrawn at random between always ready,
  // coin-flip stalls and long stalls with the odd ready cycle
  always @(posedge clk) begin
    if (stall_cyc % 64 == 0) stall_mode <= $urandom_range(0, 2);
    stall_cyc <= stall_cyc + 1;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // one pixel beat, with a random gap ahead of each new burst
  task automatic send_pixel(logic [7:0] pix, logic eof);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_data.pixel <= pix;
    in_data.end_of_frame <= eof;
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  // wait until every band result is back, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_regs(int thr, int mg, int minp, int nw, int wd, int ht);
    int vals [6];
    vals = '{thr, mg, minp, nw, wd, ht};
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= swls_pkg::cfg_reg_t'(i);
      cfg_data  <= swls_pkg::CFG_DATA_W'(vals[i]);
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // a frame of len pixels, lane-like columns near la and lb plus noise
  task automatic send_frame(int len, int ew, int thr);
    int la, lb, col;
    logic [7:0] pix;
    la = $urandom_range(0, ew / 2);
    lb = $urandom_range(ew / 2, ew - 1);
    for (int i = 0; i < len; i++) begin
      col = i % ew;
      if ($urandom_range(0, 3) == 0)
        pix = $urandom_range(0, 255);
      else if (col == la || col == lb || col == la + 1)
        pix = $urandom_range(thr < 255 ? thr + 1 : 255, 255);
      else
        pix = $urandom_range(0, thr);
      send_pixel(pix, i == len - 1);
    end
  endtask

  // one setting: the first frame fills the whole image so that no stale
  // entry is ever read, later frames may end early or run long
  task automatic run_phase(int thr, int mg, int minp, int nw, int wd, int ht, int frames);
    int ew, eh, full, len;
    ew = wd < 1 ? 1 : (wd > 1024 ? 1024 : wd);
    eh = ht < 1 ? 1 : (ht > 512 ? 512 : ht);
    full = ew * eh;
    // row 0 is never searched, so a one-row frame need not be filled
    if (eh == 1 && full > 16) full = 16;
    write_regs(thr, mg, minp, nw, wd, ht);
    for (int f = 0; f < frames; f++) begin
      len = full;
      if (f > 0)
        case ($urandom_range(0, 2))
          0: len = full > 1 ? $urandom_range(1, full - 1) : 1;
          1: len = full + $urandom_range(1, 4);
          default: ;
        endcase
      send_frame(len, ew, thr);
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    burst_left = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed settings: smallest frame, full threshold range, widest
    // margin, most bands, saturated width and window count, zeros
    run_phase(128, 1, 0, 1, 2, 1, 2);
    run_phase(0, 255, 0, 64, 4, 3, 1);
    run_phase(255, 1, 524287, 3, 2047, 1, 1);
    run_phase(7, 1, 0, 0, 0, 0, 4);
    run_phase(100, 2, 1, 127, 2, 8, 1);
    run_phase(60, 3, 2, 8, 1024, 1, 1);
    run_phase(90, 1, 0, 2, 4, 4, 2);

    // random settings, small frames
    for (int p = 0; p < 3; p++)
      run_phase($urandom_range(20, 200), $urandom_range(1, 6), $urandom_range(0, 4),
                ($urandom_range(0, 5) == 0) ? 64 : $urandom_range(1, 8),
                $urandom_range(2, 4), $urandom_range(1, 3), $urandom_range(1, 2));

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
